// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers, included by ffb_seq.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/ffb_pkg.sv -----
// ---------------------------------------------------------------------------
// ffb_pkg
// Types, constants and the CRC-16 byte fold for the frame builder.
// ---------------------------------------------------------------------------
package ffb_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  FLAG_RESET = 8'h7E;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_CLOSE
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eof;
  } res_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {crc[15:8], 8'h00};
    for (int i = 0; i < 8; i++) begin
      t = t[15] ? ({t[14:0], 1'b0} ^ CRC_POLY) : {t[14:0], 1'b0};
    end
    return t ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

// ----- hw/rtl/ffb_seq.sv -----
// ---------------------------------------------------------------------------
// ffb_seq
// Holds one request, steps it through flag, data and trailer bytes and
// keeps the running CRC, frame state and flag register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffb_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          res_ready,
  output ffb_pkg::res_t res
);
  import ffb_pkg::*;

  logic        hold_vld_r, hold_vld_nxt;
  logic [7:0]  hold_data_r;
  logic        hold_last_r;
  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        inside_r, inside_nxt;
  logic [7:0]  flag_r;
  logic        adv, done, in_take;

  assign adv      = hold_vld_r && res_ready;
  assign in_stall = hold_vld_r && !done;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    inside_nxt = inside_r;
    done       = 1'b0;
    res        = '0;
    if (hold_vld_r) begin
      res.valid = 1'b1;
      unique case (phase_r)
        PH_HEAD: begin
          if (!inside_r) begin
            res.data   = flag_r;
            inside_nxt = 1'b1;
          end else begin
            res.data  = hold_data_r;
            crc_nxt   = crc_fold(crc_r, hold_data_r);
            phase_nxt = hold_last_r ? PH_CRC_LO : PH_HEAD;
            done      = !hold_last_r;
          end
        end
        PH_CRC_LO: begin
          res.data  = crc_r[7:0];
          phase_nxt = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          res.data  = crc_r[15:8];
          phase_nxt = PH_CLOSE;
        end
        PH_CLOSE: begin
          res.data   = flag_r;
          res.eof    = 1'b1;
          crc_nxt    = '0;
          inside_nxt = 1'b0;
          done       = 1'b1;
        end
        default: begin
          res.data = flag_r;
        end
      endcase
    end
    done = done && adv;
  end

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (in_take) begin
      hold_vld_nxt = 1'b1;
    end else if (done) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      phase_r    <= PH_HEAD;
      crc_r      <= '0;
      inside_r   <= 1'b0;
      flag_r     <= FLAG_RESET;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      if (cfg_wr_en) begin
        flag_r <= cfg_wr_data;
      end
      if (adv) begin
        crc_r    <= crc_nxt;
        inside_r <= inside_nxt;
      end
      if (in_take) begin
        phase_r <= PH_HEAD;
      end else if (adv) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_data_r <= in_data_byte;
      hold_last_r <= in_last_byte;
    end
  end

  `ASSERT_CLK(a_eof_is_flag, res.valid && res.eof |-> res.data == flag_r, "eof byte is not the flag")
  `ASSERT_CLK(a_close_clears, adv && phase_r == PH_CLOSE |=> crc_r == '0 && !inside_r, "close did not clear frame state")
  `ASSERT_NEVER(a_stall_when_empty, !hold_vld_r && in_stall, "input stalled with empty hold stage")

endmodule

// ----- hw/rtl/ffb_out.sv -----
// ---------------------------------------------------------------------------
// ffb_out
// Output register stage: holds one result byte until the receiver takes it.
// ---------------------------------------------------------------------------
module ffb_out (
  input  logic          clk,
  input  logic          rst_n,
  input  ffb_pkg::res_t res,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_end_of_frame
);
  import ffb_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eof_r;

  assign res_ready = !valid_r || !out_stall;
  assign valid_nxt = res_ready ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      byte_r <= res.data;
      eof_r  <= res.eof;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_end_of_frame = eof_r;

endmodule

// ----- hw/rtl/flag_crc16_frame_builder_unit.sv -----
// ---------------------------------------------------------------------------
// flag_crc16_frame_builder_unit
// Builds flagged frames with a CRC-16 (poly 0x1021, init 0) trailer.
// ---------------------------------------------------------------------------
// Input channel (in_*): one message byte per request, in_last_byte marks the
// final byte of a message. Output channel (out_*): one framed byte per
// request: opening flag, data bytes, CRC low, CRC high, closing flag with
// out_end_of_frame set. cfg_wr_en/cfg_wr_data load the flag byte.
// Each result is registered in the output stage. Throughput, while the
// receiver does not stall: one output byte per cycle; inside a frame a
// data byte is taken every cycle. The first byte of a frame is held for
// flag and data, the last for data, two CRC bytes and flag; the single
// hold stage sets that pace, in_stall stays high meanwhile.
// Reset: no frame open, CRC zero, flag 0x7E, no result pending.
// Receiver stall: the output register holds its byte, the hold stage stops
// advancing and in_stall rises once the hold stage is full.
// ---------------------------------------------------------------------------
module flag_crc16_frame_builder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_end_of_frame
);
  import ffb_pkg::*;

  res_t res;
  logic res_ready;

  ffb_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .res_ready    (res_ready),
    .res          (res)
  );

  ffb_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .res_ready        (res_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ----- tb/sv/ffb_frame_monitor.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ffb_frame_monitor
// Watches the frame builder's ports, rebuilds the framed byte stream from the
// accepted message bytes and the flag register, and compares every accepted
// output byte against it in order.
// ---------------------------------------------------------------------------
module ffb_frame_monitor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_end_of_frame,
  output int         mismatch_count,
  output int         bytes_pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
  } framed_byte_t;

  framed_byte_t expected_frame_bytes[$];
  logic [15:0]  frame_crc;
  logic         frame_open;
  logic [7:0]   flag_byte;
  int           errors = 0;

  function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] acc;
    acc = {crc[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ ffb_pkg::CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc ^ {crc[7:0], 8'h00} ^ {8'h00, data};
  endfunction

  task automatic expect_byte(input logic [7:0] value, input logic eof);
    framed_byte_t item;
    item.value = value;
    item.eof   = eof;
    expected_frame_bytes.push_back(item);
  endtask

  task automatic predict_frame_bytes(input logic [7:0] data, input logic last);
    if (!frame_open) begin
      expect_byte(flag_byte, 1'b0);
      frame_open = 1'b1;
    end
    expect_byte(data, 1'b0);
    frame_crc = crc16_fold_byte(frame_crc, data);
    if (last) begin
      expect_byte(frame_crc[7:0], 1'b0);
      expect_byte(frame_crc[15:8], 1'b0);
      expect_byte(flag_byte, 1'b1);
      frame_crc  = '0;
      frame_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    framed_byte_t want;
    if (!rst_n) begin
      flag_byte  = ffb_pkg::FLAG_RESET;
      frame_crc  = '0;
      frame_open = 1'b0;
      expected_frame_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        flag_byte = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        predict_frame_bytes(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_frame_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected output: byte %02h eof %0b", out_byte, out_end_of_frame);
          end
        end else begin
          want = expected_frame_bytes.pop_front();
          if (want.value !== out_byte || want.eof !== out_end_of_frame) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected byte %02h eof %0b, got byte %02h eof %0b",
                       want.value, want.eof, out_byte, out_end_of_frame);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    bytes_pending  <= expected_frame_bytes.size();
  end

endmodule

// ----- tb/sv/tb_flag_crc16_frame_builder_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_flag_crc16_frame_builder_unit
// Drives message bytes and flag register writes into the frame builder,
// with random idle bursts on both channels, and reports the verdict from
// the frame monitor's mismatch and pending byte counts.
// ---------------------------------------------------------------------------
module tb_flag_crc16_frame_builder_unit;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_end_of_frame;

  int         mismatch_count;
  int         bytes_pending;
  int         cycle_count = 0;
  int         gap_odds;
  int         stall_odds;
  logic [7:0] flag_now;

  always #5 clk = ~clk;

  flag_crc16_frame_builder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_end_of_frame (out_end_of_frame)
  );

  ffb_frame_monitor frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_end_of_frame (out_end_of_frame),
    .mismatch_count   (mismatch_count),
    .bytes_pending    (bytes_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_odds == 0) begin
        out_stall  <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(1, stall_odds) == 1) begin
          stall_left = $urandom_range(1, 13);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_gap();
    int n;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted byte has left the block
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_flag(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    flag_now    = value;
  endtask

  task automatic send_frame(input int len);
    logic [7:0] data;
    for (int i = 0; i < len; i++) begin
      data = ($urandom_range(0, 7) == 0) ? flag_now : 8'($urandom_range(0, 255));
      send_byte(data, i == len - 1);
      maybe_gap();
    end
  endtask

  initial begin
    int sent;
    int len;
    int pick;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 8'h00;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    gap_odds     = 0;
    stall_odds   = 0;
    flag_now     = ffb_pkg::FLAG_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte frames at both data extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // flag value inside the data, passed through unstuffed
    send_byte(flag_now, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(flag_now, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'h31 + 8'(i), i == 7);
    end
    drain();
    write_flag(8'h00);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
    write_flag(8'hFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b1);
    // change the flag while a frame is open
    send_byte(8'hA5, 1'b0);
    drain();
    write_flag(8'h3C);
    send_byte(8'h5A, 1'b1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin
          gap_odds   = 4;
          stall_odds = 5;
          write_flag(8'($urandom_range(0, 255)));
        end
        1: begin
          gap_odds   = 0;
          stall_odds = 3;
          write_flag(8'h00);
        end
        2: begin
          gap_odds   = 2;
          stall_odds = 0;
          write_flag(8'hFF);
        end
        3: begin
          gap_odds   = 3;
          stall_odds = 2;
          write_flag(8'($urandom_range(0, 255)));
        end
        default: begin
          gap_odds   = 0;
          stall_odds = 0;
          write_flag(ffb_pkg::FLAG_RESET);
        end
      endcase
      sent = 0;
      while (sent < 78) begin
        pick = $urandom_range(0, 15);
        if (pick < 12) begin
          len = $urandom_range(1, 6);
        end else if (pick < 15) begin
          len = $urandom_range(7, 20);
        end else begin
          len = $urandom_range(21, 48);
        end
        send_frame(len);
        sent += len;
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ffb_pkg.sv
hw/rtl/ffb_seq.sv
hw/rtl/ffb_out.sv
hw/rtl/flag_crc16_frame_builder_unit.sv
tb/sv/ffb_frame_monitor.sv
tb/sv/tb_flag_crc16_frame_builder_unit.sv
